// ----- hw/rtl/rrss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_pkg
// Types and codes of the round-robin slice scheduler.
// ----------------------------------------------------------------------------
package rrss_pkg;

   localparam int unsigned ARRIVAL_W  = 16;
   localparam int unsigned BURST_W    = 16;
   localparam int unsigned QUANTUM_W  = 16;
   localparam int unsigned OUT_TIME_W = 24;
   localparam int unsigned OUT_ID_W   = 6;
   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd25;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_UNUSED   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_SLICE  = 2'd0,
      ST_DONE   = 2'd1,
      ST_REJECT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CH_HOLD   = 2'd0,
      CH_INSERT = 2'd1,
      CH_POP    = 2'd2,
      CH_CLEAR  = 2'd3
   } chain_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADMIT_PRE,
      S_POP,
      S_FETCH,
      S_READ,
      S_EXEC,
      S_ADMIT_POST,
      S_FIN
   } state_type;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [ARRIVAL_W-1:0] arrival;
      logic [BURST_W-1:0]   burst;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [OUT_ID_W-1:0]   proc_id;
      logic [OUT_TIME_W-1:0] slice_start;
      logic [OUT_TIME_W-1:0] slice_end;
      logic                  finished;
      logic [OUT_TIME_W-1:0] turnaround;
      logic [OUT_TIME_W-1:0] waiting;
      logic [OUT_TIME_W-1:0] response;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ----- hw/rtl/rrss_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_cell
// One cell of the arrival chain: holds one (arrival, id) entry, takes part
// in sorted insertion and shifts toward the head on admission.
// ----------------------------------------------------------------------------
module rrss_cell
   import rrss_pkg::*;
#(
   parameter int unsigned ID_W = 6
) (
   input  wire                       clock,
   input  wire                       reset,
   input  chain_op_type              op,
   input  wire  [ARRIVAL_W-1:0]      new_arrival,
   input  wire  [ID_W-1:0]           new_id,
   input  wire                       left_valid,
   input  wire  [ARRIVAL_W-1:0]      left_arrival,
   input  wire  [ID_W-1:0]           left_id,
   input  wire                       right_valid,
   input  wire  [ARRIVAL_W-1:0]      right_arrival,
   input  wire  [ID_W-1:0]           right_id,
   output logic                      valid,
   output logic [ARRIVAL_W-1:0]      arrival,
   output logic [ID_W-1:0]           id
);

   logic                 valid_ff, valid_in;
   logic [ARRIVAL_W-1:0] arrival_ff, arrival_in;
   logic [ID_W-1:0]      id_ff, id_in;

   always_comb begin
      valid_in   = valid_ff;
      arrival_in = arrival_ff;
      id_in      = id_ff;
      unique case (op)
         CH_HOLD: begin
         end
         CH_INSERT: begin
            if (valid_ff && (arrival_ff <= new_arrival)) begin
            end else if (left_valid && (left_arrival > new_arrival)) begin
               valid_in   = 1'b1;
               arrival_in = left_arrival;
               id_in      = left_id;
            end else if (left_valid) begin
               valid_in   = 1'b1;
               arrival_in = new_arrival;
               id_in      = new_id;
            end
         end
         CH_POP: begin
            valid_in   = right_valid;
            arrival_in = right_arrival;
            id_in      = right_id;
         end
         CH_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      arrival_ff <= arrival_in;
      id_ff      <= id_in;
   end

   assign valid   = valid_ff;
   assign arrival = arrival_ff;
   assign id      = id_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/rrss_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_chain
// Row of cells kept in (arrival, load index) order; the head is the next
// process to admit.
// ----------------------------------------------------------------------------
module rrss_chain
   import rrss_pkg::*;
#(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned ID_W  = 6
) (
   input  wire                       clock,
   input  wire                       reset,
   input  chain_op_type              op,
   input  wire  [ARRIVAL_W-1:0]      new_arrival,
   input  wire  [ID_W-1:0]           new_id,
   output logic                      head_valid,
   output logic [ARRIVAL_W-1:0]      head_arrival,
   output logic [ID_W-1:0]           head_id
);

   logic [DEPTH-1:0]                 cell_valid;
   logic [DEPTH-1:0][ARRIVAL_W-1:0]  cell_arrival;
   logic [DEPTH-1:0][ID_W-1:0]       cell_id;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 lv, rv;
      logic [ARRIVAL_W-1:0] la, ra;
      logic [ID_W-1:0]      li, ri;

      if (i == 0) begin : g_first
         assign lv = 1'b1;
         assign la = '0;
         assign li = '0;
      end else begin : g_mid
         assign lv = cell_valid[i-1];
         assign la = cell_arrival[i-1];
         assign li = cell_id[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign rv = 1'b0;
         assign ra = '0;
         assign ri = '0;
      end else begin : g_inner
         assign rv = cell_valid[i+1];
         assign ra = cell_arrival[i+1];
         assign ri = cell_id[i+1];
      end

      rrss_cell #(
         .ID_W (ID_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .op            (op),
         .new_arrival   (new_arrival),
         .new_id        (new_id),
         .left_valid    (lv),
         .left_arrival  (la),
         .left_id       (li),
         .right_valid   (rv),
         .right_arrival (ra),
         .right_id      (ri),
         .valid         (cell_valid[i]),
         .arrival       (cell_arrival[i]),
         .id            (cell_id[i])
      );
   end

   assign head_valid   = cell_valid[0];
   assign head_arrival = cell_arrival[0];
   assign head_id      = cell_id[0];

endmodule
`default_nettype wire

// ----- hw/rtl/round_robin_slice_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Load and clear act on the accepted request; a rejected load or an empty dispatch answers next cycle.
// Dispatch states: admit-pre, pop, fetch, read, exec, admit-post, fin. Both admit states
// repeat per process admitted from the arrival chain; admit-pre also repeats per ready-queue jump.
// Reset is synchronous: quantum returns to 25, the chain and ready queue empty, all
// counters and the clock clear. Table memories are not cleared.
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler
// Round-robin time-slice scheduler: loads and clears processes, hands out at most one slice per
// dispatch transfer and reports completion times.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler
   import rrss_pkg::*;
#(
   parameter int unsigned MAX_PROCS = 64,
   parameter int unsigned TIME_BITS = 24
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  req_payload_type         req_payload,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output rsp_payload_type         rsp_payload,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire  [QUANTUM_W-1:0]    csr_data
);

   localparam int unsigned ID_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int unsigned CW   = $clog2(MAX_PROCS + 1);
   localparam int unsigned TW   = TIME_BITS;
   localparam logic [CW-1:0]   MAX_CNT = CW'(MAX_PROCS);
   localparam logic [ID_W-1:0] LAST_ID = ID_W'(MAX_PROCS - 1);

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        done_cnt_ff, done_cnt_in;
   logic                 running_ff, running_in;
   logic [TW-1:0]        clock_ff, clock_in;
   logic [QUANTUM_W-1:0] quantum_ff;
   logic [ID_W-1:0]      head_ff, head_in;
   logic [ID_W-1:0]      tail_ff, tail_in;
   logic [CW-1:0]        size_ff, size_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [TW-1:0]        start_ff, start_in;
   logic [TW-1:0]        fs_ff, fs_in;
   logic                 fin_ff, fin_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;
   logic [MAX_PROCS-1:0] started_ff, started_in;

   logic [ARRIVAL_W-1:0] arr_mem [MAX_PROCS];
   logic [BURST_W-1:0]   bur_mem [MAX_PROCS];
   logic [BURST_W-1:0]   rem_mem [MAX_PROCS];
   logic [TW-1:0]        fs_mem  [MAX_PROCS];
   logic [ID_W-1:0]      fifo_mem [MAX_PROCS];

   logic [ARRIVAL_W-1:0] arr_rd_ff;
   logic [BURST_W-1:0]   bur_rd_ff;
   logic [BURST_W-1:0]   rem_rd_ff;
   logic [TW-1:0]        fs_rd_ff;
   logic [ID_W-1:0]      fifo_rd_ff;

   chain_op_type         chain_op;
   logic                 head_valid;
   logic [ARRIVAL_W-1:0] head_arrival;
   logic [ID_W-1:0]      head_id;

   logic                 req_xfer;
   logic                 admit_ok;
   logic                 load_we;
   logic                 exec_we;
   logic                 push_en;
   logic [ID_W-1:0]      push_id;
   logic [QUANTUM_W-1:0] q_eff;
   logic [BURST_W-1:0]   run;
   logic                 done_now;
   logic [TW:0]          sum;
   logic [TW-1:0]        clk_new;
   logic [TW-1:0]        turn;
   logic [TW-1:0]        wait_t;
   logic [TW-1:0]        resp_t;
   logic [31:0]          start_x, end_x, turn_x, wait_x, resp_x, id_x;

   rrss_chain #(
      .DEPTH (MAX_PROCS),
      .ID_W  (ID_W)
   ) u_chain (
      .clock        (clock),
      .reset        (reset),
      .op           (chain_op),
      .new_arrival  (req_payload.arrival),
      .new_id       (count_ff[ID_W-1:0]),
      .head_valid   (head_valid),
      .head_arrival (head_arrival),
      .head_id      (head_id)
   );

   assign req_xfer  = req_valid && req_ready;
   assign admit_ok  = head_valid && (TW'(head_arrival) <= clock_ff);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign q_eff    = (quantum_ff == '0) ? QUANTUM_W'(1) : quantum_ff;
   assign run      = (rem_rd_ff < q_eff) ? rem_rd_ff : q_eff;
   assign done_now = (rem_rd_ff <= q_eff);
   assign sum      = {1'b0, clock_ff} + (TW + 1)'(run);
   assign clk_new  = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
   assign turn     = clock_ff - TW'(arr_rd_ff);
   assign wait_t   = (turn >= TW'(bur_rd_ff)) ? (turn - TW'(bur_rd_ff)) : '0;
   assign resp_t   = fs_ff - TW'(arr_rd_ff);
   assign start_x  = 32'(start_ff);
   assign end_x    = 32'(clock_ff);
   assign turn_x   = 32'(turn);
   assign wait_x   = 32'(wait_t);
   assign resp_x   = 32'(resp_t);
   assign id_x     = 32'(id_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_payload.opcode == OP_DISPATCH) &&
                (count_ff != '0) && (done_cnt_ff < count_ff)) begin
               state_in = S_ADMIT_PRE;
            end
         end
         S_ADMIT_PRE: begin
            if (!admit_ok && (size_ff != '0)) begin
               state_in = S_POP;
            end else if (!admit_ok && !head_valid) begin
               state_in = S_IDLE;
            end
         end
         S_POP:        state_in = S_FETCH;
         S_FETCH:      state_in = S_READ;
         S_READ:       state_in = S_EXEC;
         S_EXEC:       state_in = S_ADMIT_POST;
         S_ADMIT_POST: begin
            if (!admit_ok) begin
               state_in = S_FIN;
            end
         end
         S_FIN:        state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = (state_ff == S_IDLE) && !rsp_valid_ff;
      count_in     = count_ff;
      done_cnt_in  = done_cnt_ff;
      running_in   = running_ff;
      clock_in     = clock_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      size_in      = size_ff;
      id_in        = id_ff;
      start_in     = start_ff;
      fs_in        = fs_ff;
      fin_in       = fin_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      chain_op     = CH_HOLD;
      load_we      = 1'b0;
      exec_we      = 1'b0;
      push_en      = 1'b0;
      push_id      = head_id;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               unique case (req_payload.opcode)
                  OP_LOAD: begin
                     if (running_ff || (count_ff >= MAX_CNT)) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in        = '0;
                        rsp_data_in.status = ST_REJECT;
                     end else begin
                        load_we  = 1'b1;
                        chain_op = CH_INSERT;
                        started_in[count_ff[ID_W-1:0]] = 1'b0;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_DISPATCH: begin
                     if ((count_ff == '0) || (done_cnt_ff >= count_ff)) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in        = '0;
                        rsp_data_in.status = ST_DONE;
                     end else if (!running_ff) begin
                        running_in = 1'b1;
                        clock_in   = TW'(head_arrival);
                     end
                  end
                  OP_CLEAR: begin
                     chain_op    = CH_CLEAR;
                     count_in    = '0;
                     done_cnt_in = '0;
                     running_in  = 1'b0;
                     clock_in    = '0;
                     head_in     = '0;
                     tail_in     = '0;
                     size_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADMIT_PRE: begin
            if (admit_ok) begin
               chain_op = CH_POP;
               push_en  = 1'b1;
            end else if (size_ff == '0) begin
               if (head_valid) begin
                  clock_in = TW'(head_arrival);
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in        = '0;
                  rsp_data_in.status = ST_DONE;
               end
            end
         end
         S_POP: begin
         end
         S_FETCH: begin
            id_in   = fifo_rd_ff;
            head_in = (head_ff == LAST_ID) ? '0 : head_ff + ID_W'(1);
            size_in = size_ff - CW'(1);
         end
         S_READ: begin
         end
         S_EXEC: begin
            exec_we  = 1'b1;
            start_in = clock_ff;
            clock_in = clk_new;
            fin_in   = done_now;
            if (started_ff[id_ff]) begin
               fs_in = fs_rd_ff;
            end else begin
               fs_in = clock_ff;
               started_in[id_ff] = 1'b1;
            end
            if (done_now) begin
               done_cnt_in = done_cnt_ff + CW'(1);
            end
         end
         S_ADMIT_POST: begin
            if (admit_ok) begin
               chain_op = CH_POP;
               push_en  = 1'b1;
            end else if (!fin_ff) begin
               push_en = 1'b1;
               push_id = id_ff;
            end
         end
         S_FIN: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in             = '0;
            rsp_data_in.status      = ST_SLICE;
            rsp_data_in.proc_id     = id_x[OUT_ID_W-1:0];
            rsp_data_in.slice_start = start_x[OUT_TIME_W-1:0];
            rsp_data_in.slice_end   = end_x[OUT_TIME_W-1:0];
            rsp_data_in.finished    = fin_ff;
            if (fin_ff) begin
               rsp_data_in.turnaround = turn_x[OUT_TIME_W-1:0];
               rsp_data_in.waiting    = wait_x[OUT_TIME_W-1:0];
               rsp_data_in.response   = resp_x[OUT_TIME_W-1:0];
            end
         end
         default: begin
         end
      endcase

      if (push_en && (size_ff < MAX_CNT)) begin
         tail_in = (tail_ff == LAST_ID) ? '0 : tail_ff + ID_W'(1);
         size_in = size_in + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         done_cnt_ff  <= '0;
         running_ff   <= 1'b0;
         clock_ff     <= '0;
         quantum_ff   <= QUANTUM_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         size_ff      <= '0;
         started_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         done_cnt_ff  <= done_cnt_in;
         running_ff   <= running_in;
         clock_ff     <= clock_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         size_ff      <= size_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            quantum_ff <= csr_data;
         end
      end
      id_ff       <= id_in;
      start_ff    <= start_in;
      fs_ff       <= fs_in;
      fin_ff      <= fin_in;
      rsp_data_ff <= rsp_data_in;
   end

   // process tables
   always_ff @(posedge clock) begin
      if (load_we) begin
         arr_mem[count_ff[ID_W-1:0]] <= req_payload.arrival;
         bur_mem[count_ff[ID_W-1:0]] <= req_payload.burst;
      end
      if (load_we) begin
         rem_mem[count_ff[ID_W-1:0]] <= req_payload.burst;
      end else if (exec_we) begin
         rem_mem[id_ff] <= rem_rd_ff - run;
      end
      if (exec_we && !started_ff[id_ff]) begin
         fs_mem[id_ff] <= clock_ff;
      end
      arr_rd_ff <= arr_mem[id_ff];
      bur_rd_ff <= bur_mem[id_ff];
      rem_rd_ff <= rem_mem[id_ff];
      fs_rd_ff  <= fs_mem[id_ff];
   end

   // ready queue
   always_ff @(posedge clock) begin
      if (push_en && (size_ff < MAX_CNT)) begin
         fifo_mem[tail_ff] <= push_id;
      end
      fifo_rd_ff <= fifo_mem[head_ff];
   end

endmodule
`default_nettype wire
